// ===== design/utd_pkg.sv =====
// shared types and constants for the utf-8 to utf-16 decoder
package utd_pkg;

  // one input beat: a utf-8 byte and its end-of-text flag
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
  } in_beat_t;

  // one output beat: a utf-16 code unit with its status and markers
  typedef struct packed {
    logic [15:0] code_unit;
    logic [1:0]  status;
    logic        run_last;
    logic        text_done;
  } out_beat_t;

  // status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_ILLEGAL   = 2'd1;
  localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

  // extra limit on the first continuation byte, chosen by the lead byte
  typedef enum logic [2:0] {
    RULE_NONE   = 3'd0,
    RULE_MIN_A0 = 3'd1,
    RULE_MAX_9F = 3'd2,
    RULE_MIN_90 = 3'd3,
    RULE_MAX_8F = 3'd4,
    RULE_FAIL   = 3'd5
  } rule_t;

  // byte boundaries
  localparam logic [7:0] ASCII_LIMIT    = 8'h80;
  localparam logic [7:0] LEAD_MIN       = 8'hC2;
  localparam logic [7:0] LEAD3_MIN      = 8'hE0;
  localparam logic [7:0] LEAD4_MIN      = 8'hF0;
  localparam logic [7:0] LEAD_LIMIT     = 8'hF8;
  localparam logic [7:0] LEAD3_LOW      = 8'hE0;
  localparam logic [7:0] LEAD3_SURR     = 8'hED;
  localparam logic [7:0] LEAD4_LOW      = 8'hF0;
  localparam logic [7:0] LEAD4_TOP      = 8'hF4;
  localparam logic [7:0] CONT_BOUND_A0  = 8'hA0;
  localparam logic [7:0] CONT_BOUND_90  = 8'h90;

  // code point and surrogate constants
  localparam logic [20:0] SUPP_BASE = 21'h10000;
  localparam logic [15:0] HIGH_SURR = 16'hD800;
  localparam logic [15:0] LOW_SURR  = 16'hDC00;

  // results produced by one byte
  typedef struct packed {
    logic [1:0] count;
    out_beat_t  first;
    out_beat_t  second;
  } step_t;

endpackage

// ===== design/utf8_to_utf16_decoder_unit.sv =====
// utf-8 to utf-16 decoder top level
// results: a byte's code units go into the result register behind any held beats
// throughput: one byte per cycle; a byte waits only while the result register has
//   no room for its code units, which happens only when the result side stalls
// reset: synchronous rst clears the decode state and empties the result register
module utf8_to_utf16_decoder_unit
  import utd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      text_valid,
  output logic      text_ready,
  input  in_beat_t  text_byte,
  output logic      unit_valid,
  input  logic      unit_ready,
  output out_beat_t unit
);

  step_t step;
  logic  accept;

  assign accept = text_valid && text_ready;

  // per-byte decode
  utd_decode u_decode (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .beat   (text_byte),
    .step   (step)
  );

  // result register
  utd_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .step       (step),
    .can_take   (text_ready),
    .unit_valid (unit_valid),
    .unit_ready (unit_ready),
    .unit       (unit)
  );

endmodule

// ===== design/utd_decode.sv =====
// running decode state and per-byte result logic
module utd_decode
  import utd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  in_beat_t beat,
  output step_t    step
);

  logic [1:0]  bytes_remaining, bytes_remaining_next;
  logic [20:0] partial_value, partial_value_next;
  rule_t       second_byte_rule, second_byte_rule_next;
  logic        error_pending, error_pending_next;
  logic        discarding, discarding_next;

  logic [7:0]  b;
  logic        fin;
  logic        rule_ok;
  logic        cont_ok;
  logic [20:0] shifted;
  logic [20:0] offset;
  logic [1:0]  rem_dec;
  logic        done;
  out_beat_t   r0, r1;
  logic [1:0]  n;

  assign b   = beat.data_byte;
  assign fin = beat.end_of_text;

  // limit check on the first continuation byte
  always_comb begin
    unique case (second_byte_rule)
      RULE_NONE:   rule_ok = 1'b1;
      RULE_MIN_A0: rule_ok = (b >= CONT_BOUND_A0);
      RULE_MAX_9F: rule_ok = (b < CONT_BOUND_A0);
      RULE_MIN_90: rule_ok = (b >= CONT_BOUND_90);
      RULE_MAX_8F: rule_ok = (b < CONT_BOUND_90);
      default:     rule_ok = 1'b0;
    endcase
  end

  assign cont_ok = (b[7:6] == 2'b10) && rule_ok;
  assign shifted = {partial_value[14:0], b[5:0]};
  assign offset  = shifted - SUPP_BASE;
  assign rem_dec = bytes_remaining - 2'd1;

  // next state and results for the byte at the input
  always_comb begin
    bytes_remaining_next  = bytes_remaining;
    partial_value_next    = partial_value;
    second_byte_rule_next = second_byte_rule;
    error_pending_next    = error_pending;
    discarding_next       = discarding;
    n    = 2'd0;
    done = 1'b0;
    r0   = '0;
    r1   = '0;

    if (discarding) begin
      if (fin) discarding_next = 1'b0;
    end else if (bytes_remaining == 2'd0) begin
      if (b < ASCII_LIMIT) begin
        r0.code_unit = {8'h00, b};
        r0.status    = STATUS_OK;
        n    = 2'd1;
        done = fin;
      end else if (b < LEAD_MIN || b >= LEAD_LIMIT) begin
        r0.status       = STATUS_ILLEGAL;
        n               = 2'd1;
        done            = 1'b1;
        discarding_next = !fin;
      end else begin
        if (b < LEAD3_MIN) begin
          bytes_remaining_next  = 2'd1;
          partial_value_next    = {16'd0, b[4:0]};
          second_byte_rule_next = RULE_NONE;
        end else if (b < LEAD4_MIN) begin
          bytes_remaining_next  = 2'd2;
          partial_value_next    = {17'd0, b[3:0]};
          second_byte_rule_next = (b == LEAD3_LOW)  ? RULE_MIN_A0 :
                                  (b == LEAD3_SURR) ? RULE_MAX_9F : RULE_NONE;
        end else begin
          bytes_remaining_next  = 2'd3;
          partial_value_next    = {18'd0, b[2:0]};
          second_byte_rule_next = (b == LEAD4_LOW) ? RULE_MIN_90 :
                                  (b == LEAD4_TOP) ? RULE_MAX_8F :
                                  (b >  LEAD4_TOP) ? RULE_FAIL   : RULE_NONE;
        end
        error_pending_next = 1'b0;
        if (fin) begin
          r0.status             = STATUS_TRUNCATED;
          n                     = 2'd1;
          done                  = 1'b1;
          bytes_remaining_next  = 2'd0;
          partial_value_next    = '0;
          second_byte_rule_next = RULE_NONE;
        end
      end
    end else begin
      second_byte_rule_next = RULE_NONE;
      error_pending_next    = error_pending | !cont_ok;
      if (rem_dec == 2'd0) begin
        if (error_pending_next) begin
          r0.status       = STATUS_ILLEGAL;
          n               = 2'd1;
          done            = 1'b1;
          discarding_next = !fin;
        end else if (shifted >= SUPP_BASE) begin
          // supplementary character: high then low surrogate
          r0.code_unit = HIGH_SURR | {6'd0, offset[19:10]};
          r1.code_unit = LOW_SURR  | {6'd0, offset[9:0]};
          r0.status    = STATUS_OK;
          r1.status    = STATUS_OK;
          n    = 2'd2;
          done = fin;
        end else begin
          r0.code_unit = shifted[15:0];
          r0.status    = STATUS_OK;
          n    = 2'd1;
          done = fin;
        end
        bytes_remaining_next  = 2'd0;
        partial_value_next    = '0;
        second_byte_rule_next = RULE_NONE;
        error_pending_next    = 1'b0;
      end else if (fin) begin
        r0.status             = STATUS_TRUNCATED;
        n                     = 2'd1;
        done                  = 1'b1;
        bytes_remaining_next  = 2'd0;
        partial_value_next    = '0;
        second_byte_rule_next = RULE_NONE;
        error_pending_next    = 1'b0;
      end else begin
        bytes_remaining_next = rem_dec;
        partial_value_next   = shifted;
      end
    end

    // markers go on the last result of the byte
    r0.run_last  = (n == 2'd1);
    r0.text_done = (n == 2'd1) && done;
    r1.run_last  = 1'b1;
    r1.text_done = done;
  end

  assign step.count  = n;
  assign step.first  = r0;
  assign step.second = r1;

  // decode state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining  <= 2'd0;
      partial_value    <= '0;
      second_byte_rule <= RULE_NONE;
      error_pending    <= 1'b0;
      discarding       <= 1'b0;
    end else if (accept) begin
      bytes_remaining  <= bytes_remaining_next;
      partial_value    <= partial_value_next;
      second_byte_rule <= second_byte_rule_next;
      error_pending    <= error_pending_next;
      discarding       <= discarding_next;
    end
  end

endmodule

// ===== design/utd_out_buf.sv =====
// two-entry result register that hands out one code unit per cycle while the result side is ready
module utd_out_buf
  import utd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  step_t     step,
  output logic      can_take,
  output logic      unit_valid,
  input  logic      unit_ready,
  output out_beat_t unit
);

  logic [1:0] count, count_next;
  out_beat_t  slot0, slot0_next;
  out_beat_t  slot1, slot1_next;
  logic       pop;
  logic [1:0] kept;
  out_beat_t  head;

  assign pop        = unit_valid && unit_ready;
  assign unit_valid = (count != 2'd0);
  assign unit       = slot0;
  // beats left after the current one leaves, and the one that becomes the head
  assign kept       = count - {1'b0, pop};
  assign head       = pop ? slot1 : slot0;
  // room for the results of the byte at the input once the current beat leaves
  assign can_take   = (step.count == 2'd0) || (kept == 2'd0) ||
                      ((kept == 2'd1) && (step.count == 2'd1));

  // append new results behind what is kept, or shift down after a pop
  always_comb begin
    count_next = count;
    slot0_next = slot0;
    slot1_next = slot1;
    if (push && step.count != 2'd0) begin
      if (kept == 2'd0) begin
        count_next = step.count;
        slot0_next = step.first;
        slot1_next = step.second;
      end else begin
        count_next = 2'd2;
        slot0_next = head;
        slot1_next = step.first;
      end
    end else if (pop) begin
      count_next = count - 2'd1;
      slot0_next = slot1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    slot0 <= slot0_next;
    slot1 <= slot1_next;
  end

endmodule

// ===== tb/sv/utf8_to_utf16_decoder_unit_tb.sv =====
// self-checking testbench for the utf-8 to utf-16 decoder unit
`timescale 1ns / 1ps

module utf8_to_utf16_decoder_unit_tb;
  import utd_pkg::*;

  logic      clk = 1'b0;
  logic      rst;
  logic      text_valid;
  logic      text_ready;
  in_beat_t  text_byte;
  logic      unit_valid;
  logic      unit_ready = 1'b0;
  out_beat_t unit;

  utf8_to_utf16_decoder_unit uut (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .text_byte  (text_byte),
    .unit_valid (unit_valid),
    .unit_ready (unit_ready),
    .unit       (unit)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decode state mirrored by the predictor
  logic [1:0]  cont_left  = '0;
  logic [20:0] code_acc   = '0;
  rule_t       first_rule = RULE_NONE;
  logic        seq_bad    = 1'b0;
  logic        dropping   = 1'b0;

  out_beat_t   expected_units[$];
  logic [7:0]  text_bytes[$];
  int          mismatches = 0;
  int          stall_left = 0;
  bit          send_gaps  = 1'b0;
  bit          sink_stalls = 1'b0;

  // leads that carry a limit on the first continuation byte
  logic [7:0]  special_leads[7] = '{8'hE0, 8'hED, 8'hF0, 8'hF4, 8'hF5, 8'hF6, 8'hF7};

  function automatic out_beat_t unit_beat(input logic [15:0] u, input logic [1:0] s);
    out_beat_t r;
    r.code_unit = u;
    r.status    = s;
    r.run_last  = 1'b0;
    r.text_done = 1'b0;
    return r;
  endfunction

  function automatic void clear_sequence();
    cont_left  = '0;
    code_acc   = '0;
    first_rule = RULE_NONE;
    seq_bad    = 1'b0;
  endfunction

  // work out the code units one accepted byte produces and queue them
  function automatic void decode_byte(input logic [7:0] b, input logic fin);
    out_beat_t   res[2];
    int          n;
    logic        done;
    logic        ok;
    logic [20:0] v;
    n = 0;
    done = 1'b0;
    if (dropping) begin
      if (fin) dropping = 1'b0;
      return;
    end
    if (cont_left == 2'd0) begin
      if (b < ASCII_LIMIT) begin
        res[n] = unit_beat({8'd0, b}, STATUS_OK);
        n = n + 1;
        done = fin;
      end else if (b < LEAD_MIN || b >= LEAD_LIMIT) begin
        res[n] = unit_beat('0, STATUS_ILLEGAL);
        n = n + 1;
        done = 1'b1;
        dropping = !fin;
      end else begin
        if (b < LEAD3_MIN) begin
          cont_left  = 2'd1;
          code_acc   = {16'd0, b[4:0]};
          first_rule = RULE_NONE;
        end else if (b < LEAD4_MIN) begin
          cont_left  = 2'd2;
          code_acc   = {17'd0, b[3:0]};
          first_rule = (b == LEAD3_LOW) ? RULE_MIN_A0 :
                       (b == LEAD3_SURR) ? RULE_MAX_9F : RULE_NONE;
        end else begin
          cont_left  = 2'd3;
          code_acc   = {18'd0, b[2:0]};
          first_rule = (b == LEAD4_LOW) ? RULE_MIN_90 :
                       (b == LEAD4_TOP) ? RULE_MAX_8F :
                       (b > LEAD4_TOP) ? RULE_FAIL : RULE_NONE;
        end
        seq_bad = 1'b0;
        // lead on the final byte is always truncated
        if (fin) begin
          res[n] = unit_beat('0, STATUS_TRUNCATED);
          n = n + 1;
          clear_sequence();
          done = 1'b1;
        end
      end
    end else begin
      ok = (b[7:6] == 2'b10);
      case (first_rule)
        RULE_MIN_A0: if (b < CONT_BOUND_A0) ok = 1'b0;
        RULE_MAX_9F: if (b >= CONT_BOUND_A0) ok = 1'b0;
        RULE_MIN_90: if (b < CONT_BOUND_90) ok = 1'b0;
        RULE_MAX_8F: if (b >= CONT_BOUND_90) ok = 1'b0;
        RULE_FAIL:   ok = 1'b0;
        default:     ;
      endcase
      first_rule = RULE_NONE;
      if (!ok) seq_bad = 1'b1;
      code_acc  = {code_acc[14:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        if (seq_bad) begin
          res[n] = unit_beat('0, STATUS_ILLEGAL);
          n = n + 1;
          done = 1'b1;
          dropping = !fin;
        end else if (code_acc >= SUPP_BASE) begin
          // supplementary character splits into a surrogate pair
          v = code_acc - SUPP_BASE;
          res[n] = unit_beat(HIGH_SURR | {6'd0, v[19:10]}, STATUS_OK);
          n = n + 1;
          res[n] = unit_beat(LOW_SURR | {6'd0, v[9:0]}, STATUS_OK);
          n = n + 1;
          done = fin;
        end else begin
          res[n] = unit_beat(code_acc[15:0], STATUS_OK);
          n = n + 1;
          done = fin;
        end
        clear_sequence();
      end else if (fin) begin
        // text ends inside a sequence, even one already known bad
        res[n] = unit_beat('0, STATUS_TRUNCATED);
        n = n + 1;
        clear_sequence();
        done = 1'b1;
      end
    end
    if (n > 0) begin
      res[n-1].run_last  = 1'b1;
      res[n-1].text_done = done;
    end
    for (int i = 0; i < n; i++) expected_units.push_back(res[i]);
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (mismatches < 40)
      $display("%0t: %s got %h expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // send one byte, with an optional idle burst ahead of it
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk);
      text_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    text_valid <= 1'b1;
    text_byte  <= '{data_byte: b, end_of_text: fin};
    do @(posedge clk); while (!text_ready);
    decode_byte(b, fin);
  endtask

  // send up to four bytes, first byte in the top lane
  task automatic send_seq(input logic [31:0] seq, input int count, input logic fin);
    for (int i = count - 1; i >= 0; i--) send_byte(seq[8*i +: 8], fin && i == 0);
  endtask

  // append the utf-8 encoding of a code point to the text
  task automatic push_char(input logic [20:0] cp);
    if (cp < 21'h80) begin
      text_bytes.push_back(cp[7:0]);
    end else if (cp < 21'h800) begin
      text_bytes.push_back({3'b110, cp[10:6]});
      text_bytes.push_back({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      text_bytes.push_back({4'b1110, cp[15:12]});
      text_bytes.push_back({2'b10, cp[11:6]});
      text_bytes.push_back({2'b10, cp[5:0]});
    end else begin
      text_bytes.push_back({5'b11110, cp[20:18]});
      text_bytes.push_back({2'b10, cp[17:12]});
      text_bytes.push_back({2'b10, cp[11:6]});
      text_bytes.push_back({2'b10, cp[5:0]});
    end
  endtask

  // result side: random stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      unit_ready <= 1'b0;
    end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 18);
      unit_ready <= 1'b0;
    end else begin
      unit_ready <= 1'b1;
    end
  end

  // compare each accepted result beat with the oldest expected one
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst && unit_valid && unit_ready) begin
      if (expected_units.size() == 0) begin
        report_mismatch("unexpected beat, code_unit", unit.code_unit, '0);
      end else begin
        want = expected_units.pop_front();
        if (unit.code_unit !== want.code_unit)
          report_mismatch("code_unit", unit.code_unit, want.code_unit);
        if (unit.status !== want.status)
          report_mismatch("status", {14'd0, unit.status}, {14'd0, want.status});
        if (unit.run_last !== want.run_last)
          report_mismatch("run_last", {15'd0, unit.run_last}, {15'd0, want.run_last});
        if (unit.text_done !== want.text_done)
          report_mismatch("text_done", {15'd0, unit.text_done}, {15'd0, want.text_done});
      end
    end
  end

  // ascii extremes, the smallest two byte character and the largest three and four byte characters
  task automatic test_valid_characters();
    send_seq(32'h0000007F, 2, 1'b0);
    send_seq(32'h0000C280, 2, 1'b0);
    send_seq(32'h00EFBFBF, 3, 1'b0);
    send_seq(32'hF48FBFBF, 4, 1'b1);
  endtask

  // bad lead inside a text drops the rest; bad lead on the final byte
  task automatic test_bad_leads();
    send_seq(32'h00C14142, 3, 1'b1);
    send_seq(32'h000000FF, 1, 1'b1);
  endtask

  // surrogate code point completing on the final byte
  task automatic test_illegal_sequences();
    send_seq(32'h00EDA080, 3, 1'b1);
  endtask

  // truncation wins over an overlong prefix; lone f5 lead on the final byte
  task automatic test_truncation();
    send_seq(32'h0000E09F, 2, 1'b1);
    send_seq(32'h000000F5, 1, 1'b1);
  endtask

  // random texts: mostly well-formed characters, some noise and broken sequences
  task automatic test_random_texts(input int byte_goal, input bit idle);
    int sent;
    int chars;
    int kind;
    int start;
    logic [7:0] lead;
    sent = 0;
    send_gaps   = idle;
    sink_stalls = idle;
    while (sent < byte_goal) begin
      text_bytes.delete();
      chars = $urandom_range(1, 10);
      for (int c = 0; c < chars; c++) begin
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
          push_char(21'($urandom_range(0, 'h7F)));
        end else if (kind < 50) begin
          push_char(21'($urandom_range('h80, 'h7FF)));
        end else if (kind < 68) begin
          push_char(21'($urandom_range('h800, 'hFFFF)));
        end else if (kind < 82) begin
          push_char(21'($urandom_range('h10000, 'h10FFFF)));
        end else if (kind < 88) begin
          text_bytes.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 94) begin
          // restricted lead with arbitrary continuation bytes
          lead = special_leads[$urandom_range(0, 6)];
          text_bytes.push_back(lead);
          repeat ((lead >= LEAD4_MIN) ? 3 : 2)
            text_bytes.push_back({2'b10, 6'($urandom_range(0, 63))});
        end else if (kind < 97) begin
          // one continuation byte replaced by anything
          start = text_bytes.size();
          push_char(21'($urandom_range('h80, 'h10FFFF)));
          text_bytes[$urandom_range(start + 1, text_bytes.size() - 1)] =
            8'($urandom_range(0, 255));
        end else begin
          // character cut short
          push_char(21'($urandom_range('h80, 'h10FFFF)));
          void'(text_bytes.pop_back());
        end
      end
      foreach (text_bytes[i]) send_byte(text_bytes[i], i == text_bytes.size() - 1);
      sent += text_bytes.size();
    end
  endtask

  initial begin
    rst        <= 1'b1;
    text_valid <= 1'b0;
    text_byte  <= '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_valid_characters();
    test_bad_leads();
    test_illegal_sequences();
    test_truncation();
    test_random_texts(1000, 1'b1);
    test_random_texts(150, 1'b0);

    @(negedge clk);
    text_valid <= 1'b0;
    while (expected_units.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_units.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/utd_pkg.sv
design/utd_decode.sv
design/utd_out_buf.sv
design/utf8_to_utf16_decoder_unit.sv
tb/sv/utf8_to_utf16_decoder_unit_tb.sv
